// ===== sv/tft_pkg.sv =====
package tft_pkg;

	localparam int MAX_SLOTS_DEF   = 10;
	localparam int MAX_TRACKED_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int RES_CW          = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] REQ_SELECT = 3'd0;
	localparam logic [2:0] REQ_TRACK  = 3'd1;
	localparam logic [2:0] REQ_X      = 3'd2;
	localparam logic [2:0] REQ_Y      = 3'd3;
	localparam logic [2:0] REQ_FRAME  = 3'd4;
	localparam logic [2:0] REQ_POLL   = 3'd5;

	localparam logic [2:0] CFG_PROBATION = 3'd0;
	localparam logic [2:0] CFG_TO_LOST   = 3'd1;
	localparam logic [2:0] CFG_LOST_TMO  = 3'd2;
	localparam logic [2:0] CFG_ACT_COUNT = 3'd3;
	localparam logic [2:0] CFG_REMATCH   = 3'd4;
	localparam logic [2:0] CFG_MOVE_MIN  = 3'd5;
	localparam logic [2:0] CFG_MOVE_MAX  = 3'd6;

	localparam logic [1:0] EV_BEGIN = 2'd0;
	localparam logic [1:0] EV_MOVE  = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	typedef enum logic [1:0] {
		MODE_PROBATION = 2'd0,
		MODE_ACTIVE    = 2'd1,
		MODE_LOST      = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR_RD, ST_CLR_WR, ST_SLOT, ST_M_RD, ST_M_CHK, ST_M_NEW,
		ST_T_START, ST_T_RD, ST_T_EVAL, ST_T_MOVE, ST_T_WB, ST_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] lid;
		logic [15:0] tid;
		mode_t       mode;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] lx;
		logic [15:0] ly;
		logic [7:0]  mc;
		logic        upd;
		logic [31:0] tm;
	} ent_t;

	typedef struct packed {
		logic [15:0] pw;
		logic [15:0] al;
		logic [15:0] lt;
		logic [7:0]  ac;
	} tmo_cfg_t;

	typedef struct packed {
		ent_t        nxt;
		logic        drop;
		logic        ev_v;
		logic [1:0]  ev_kind;
		logic        move_chk;
		logic [15:0] dx;
		logic [15:0] dy;
	} eval_t;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  kind;
		logic [15:0] x;
		logic [15:0] y;
	} evt_t;

endpackage

// ===== sv/tft_eval.sv =====
module tft_eval (
	input  tft_pkg::ent_t     e,
	input  logic [31:0]       now,
	input  tft_pkg::tmo_cfg_t c,
	output tft_pkg::eval_t    r
);

	logic [31:0] age;
	logic        old;
	logic        enough;

	always_comb begin
		age = now - e.tm;
		old = age > {16'd0, c.pw};
		enough = e.mc > c.ac;
		r.nxt = e;
		r.drop = 1'b0;
		r.ev_v = 1'b0;
		r.ev_kind = tft_pkg::EV_BEGIN;
		r.move_chk = 1'b0;
		r.dx = (e.x > e.lx) ? e.x - e.lx : e.lx - e.x;
		r.dy = (e.y > e.ly) ? e.y - e.ly : e.ly - e.y;
		if (e.mode == tft_pkg::MODE_PROBATION) begin
			if (!old && enough) begin
				r.nxt.mode = tft_pkg::MODE_ACTIVE;
				r.nxt.upd = 1'b0;
				r.nxt.tm = now;
				r.ev_v = 1'b1;
				r.ev_kind = tft_pkg::EV_BEGIN;
			end else if (old && !enough) begin
				r.drop = 1'b1;
			end
		end else if (e.mode == tft_pkg::MODE_LOST) begin
			if (e.upd) begin
				r.nxt.mode = tft_pkg::MODE_ACTIVE;
				r.nxt.upd = 1'b0;
				r.nxt.tm = now;
			end else if (age >= {16'd0, c.lt}) begin
				r.ev_v = 1'b1;
				r.ev_kind = tft_pkg::EV_END;
				r.drop = 1'b1;
			end
		end else begin
			if (e.upd) begin
				r.move_chk = 1'b1;
				r.nxt.upd = 1'b0;
				r.nxt.tm = now;
			end else if (age >= {16'd0, c.al}) begin
				r.nxt.mode = tft_pkg::MODE_LOST;
				r.nxt.tm = now;
			end
		end
	end

endmodule

// ===== sv/touch_finger_tracker.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | req_type, value, now_ms
// out     | out_valid / out_ready| finger_id, event_kind, pos_x, pos_y, last_event
// cfg     | cfg_we               | cfg_index, cfg_data
// Slot, coordinate and select words are taken while idle. A frame end sweeps the
// finger table (read, then write per finger), then walks each active slot against
// the table from the finger memory (one read and one write port), then runs the
// timeout pass (read, evaluate, move check, writeback); a poll runs that pass only.
// Reset clears control state, presets configuration; finger memory needs no clearing.
// A stalled output holds the timeout pass until the word is taken.
module touch_finger_tracker #(
	parameter int MAX_SLOTS   = tft_pkg::MAX_SLOTS_DEF,
	parameter int MAX_TRACKED = tft_pkg::MAX_TRACKED_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic signed [16:0] value,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        finger_id,
	output logic [1:0]         event_kind,
	output logic [15:0]        pos_x,
	output logic [15:0]        pos_y,
	output logic               last_event,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam int AW  = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
	localparam int CW  = $clog2(MAX_TRACKED + 1);
	localparam int NW  = tft_pkg::RES_CW;

	tft_pkg::state_t state_q, state_d;

	logic [SW-1:0]  cur_slot_q;
	logic           slot_act_q [MAX_SLOTS];
	logic [15:0]    slot_tid_q [MAX_SLOTS];
	logic [15:0]    slot_x_q   [MAX_SLOTS];
	logic [15:0]    slot_y_q   [MAX_SLOTS];

	logic [CW-1:0]  fcount_q, f_q, k_q;
	logic [SCW-1:0] s_q;
	logic [NW-1:0]  n_q;
	logic           phase_q;
	logic [15:0]    nid_q;
	logic [31:0]    now_q;

	logic [15:0]    pw_q, al_q, lt_q, rmd_q;
	logic [7:0]     ac_q;
	logic [31:0]    min_sq_q, max_sq_q;

	tft_pkg::ent_t  mem [MAX_TRACKED];
	tft_pkg::ent_t  rdat_q, wk_q, mem_wdata;
	logic           mem_re, mem_we;
	logic [AW-1:0]  mem_raddr, mem_waddr;

	logic           drop_q, evv_q;
	logic [1:0]     evk_q;
	logic [31:0]    dxsq_s1, dysq_s1;

	logic           pend_v_q, out_valid_q, out_last_q;
	tft_pkg::evt_t  pend_q, out_q;

	tft_pkg::tmo_cfg_t tcfg;
	tft_pkg::eval_t    ev;

	logic [SW-1:0]  sidx;
	logic           s_done, f_last, tid_hit, lost_hit, hit, full, ofree, ev_pass, wb_block;
	logic           in_win;
	logic [15:0]    adx, ady;
	logic [31:0]    lage;
	logic [32:0]    d2;
	tft_pkg::ent_t  ment, nent;

	assign tcfg = '{pw: pw_q, al: al_q, lt: lt_q, ac: ac_q};

	tft_eval u_eval (
		.e   (rdat_q),
		.now (now_q),
		.c   (tcfg),
		.r   (ev)
	);

	assign sidx     = s_q[SW-1:0];
	assign s_done   = s_q == SCW'(MAX_SLOTS);
	assign f_last   = CW'(f_q + 1'b1) == fcount_q;
	assign full     = fcount_q == CW'(MAX_TRACKED);
	assign ofree    = !out_valid_q || out_ready;
	assign ev_pass  = evv_q && (n_q < NW'(tft_pkg::MAX_RESULTS));
	assign wb_block = ev_pass && pend_v_q && !ofree;

	assign adx      = (rdat_q.x > slot_x_q[sidx]) ? rdat_q.x - slot_x_q[sidx]
	                                               : slot_x_q[sidx] - rdat_q.x;
	assign ady      = (rdat_q.y > slot_y_q[sidx]) ? rdat_q.y - slot_y_q[sidx]
	                                               : slot_y_q[sidx] - rdat_q.y;
	assign lage     = now_q - rdat_q.tm;
	assign tid_hit  = rdat_q.tid == slot_tid_q[sidx];
	assign lost_hit = (rdat_q.mode == tft_pkg::MODE_LOST) && (adx <= rmd_q) &&
	                  (ady <= rmd_q) && (lage < {16'd0, lt_q});
	assign hit      = phase_q ? lost_hit : tid_hit;

	assign d2     = {1'b0, dxsq_s1} + {1'b0, dysq_s1};
	assign in_win = (d2 >= {1'b0, min_sq_q}) && (d2 <= {1'b0, max_sq_q});

	always_comb begin
		ment = rdat_q;
		ment.lx = rdat_q.x;
		ment.ly = rdat_q.y;
		ment.x = slot_x_q[sidx];
		ment.y = slot_y_q[sidx];
		ment.tm = now_q;
		ment.tid = slot_tid_q[sidx];
		ment.upd = 1'b1;
		if (rdat_q.mode == tft_pkg::MODE_PROBATION && rdat_q.mc != 8'hFF) begin
			ment.mc = rdat_q.mc + 8'd1;
		end
		nent.lid = nid_q;
		nent.tid = slot_tid_q[sidx];
		nent.mode = tft_pkg::MODE_PROBATION;
		nent.x = slot_x_q[sidx];
		nent.y = slot_y_q[sidx];
		nent.lx = slot_x_q[sidx];
		nent.ly = slot_y_q[sidx];
		nent.mc = 8'd0;
		nent.upd = 1'b1;
		nent.tm = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_raddr = f_q[AW-1:0];
		mem_waddr = f_q[AW-1:0];
		mem_wdata = rdat_q;
		case (state_q)
			tft_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && req_type == tft_pkg::REQ_FRAME) begin
					state_d = (fcount_q == '0) ? tft_pkg::ST_SLOT : tft_pkg::ST_CLR_RD;
				end else if (in_valid && req_type == tft_pkg::REQ_POLL) begin
					state_d = tft_pkg::ST_T_START;
				end
			end
			tft_pkg::ST_CLR_RD: begin
				mem_re = 1'b1;
				state_d = tft_pkg::ST_CLR_WR;
			end
			tft_pkg::ST_CLR_WR: begin
				mem_we = 1'b1;
				mem_wdata.upd = 1'b0;
				state_d = f_last ? tft_pkg::ST_SLOT : tft_pkg::ST_CLR_RD;
			end
			tft_pkg::ST_SLOT: begin
				if (s_done) begin
					state_d = tft_pkg::ST_T_START;
				end else if (slot_act_q[sidx]) begin
					state_d = (fcount_q == '0) ? tft_pkg::ST_M_NEW : tft_pkg::ST_M_RD;
				end
			end
			tft_pkg::ST_M_RD: begin
				mem_re = 1'b1;
				state_d = tft_pkg::ST_M_CHK;
			end
			tft_pkg::ST_M_CHK: begin
				if (hit) begin
					mem_we = 1'b1;
					mem_wdata = ment;
					state_d = tft_pkg::ST_SLOT;
				end else if (f_last && phase_q) begin
					state_d = tft_pkg::ST_M_NEW;
				end else begin
					state_d = tft_pkg::ST_M_RD;
				end
			end
			tft_pkg::ST_M_NEW: begin
				mem_we = !full;
				mem_waddr = fcount_q[AW-1:0];
				mem_wdata = nent;
				state_d = tft_pkg::ST_SLOT;
			end
			tft_pkg::ST_T_START: begin
				state_d = (fcount_q == '0) ? tft_pkg::ST_FIN : tft_pkg::ST_T_RD;
			end
			tft_pkg::ST_T_RD: begin
				mem_re = 1'b1;
				state_d = tft_pkg::ST_T_EVAL;
			end
			tft_pkg::ST_T_EVAL: begin
				state_d = ev.move_chk ? tft_pkg::ST_T_MOVE : tft_pkg::ST_T_WB;
			end
			tft_pkg::ST_T_MOVE: begin
				state_d = tft_pkg::ST_T_WB;
			end
			tft_pkg::ST_T_WB: begin
				mem_waddr = k_q[AW-1:0];
				mem_wdata = wk_q;
				if (!wb_block) begin
					mem_we = !drop_q;
					state_d = f_last ? tft_pkg::ST_FIN : tft_pkg::ST_T_RD;
				end
			end
			tft_pkg::ST_FIN: begin
				if (!pend_v_q || ofree) begin
					state_d = tft_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tft_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdat_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= 16'd50;
			al_q <= 16'd50;
			lt_q <= 16'd50;
			ac_q <= 8'd4;
			rmd_q <= 16'd30;
			min_sq_q <= 32'd4;
			max_sq_q <= 32'd900;
		end else if (cfg_we) begin
			case (cfg_index)
				tft_pkg::CFG_PROBATION: pw_q <= cfg_data;
				tft_pkg::CFG_TO_LOST:   al_q <= cfg_data;
				tft_pkg::CFG_LOST_TMO:  lt_q <= cfg_data;
				tft_pkg::CFG_ACT_COUNT: ac_q <= cfg_data[7:0];
				tft_pkg::CFG_REMATCH:   rmd_q <= cfg_data;
				tft_pkg::CFG_MOVE_MIN:  min_sq_q <= cfg_data * cfg_data;
				tft_pkg::CFG_MOVE_MAX:  max_sq_q <= cfg_data * cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_act_q[i] <= 1'b0;
				slot_tid_q[i] <= 16'd0;
				slot_x_q[i] <= 16'd0;
				slot_y_q[i] <= 16'd0;
			end
		end else if (state_q == tft_pkg::ST_IDLE && in_valid) begin
			case (req_type)
				tft_pkg::REQ_SELECT: begin
					if (!value[16] && value[15:0] < 16'(MAX_SLOTS)) begin
						cur_slot_q <= value[SW-1:0];
					end
				end
				tft_pkg::REQ_TRACK: begin
					slot_act_q[cur_slot_q] <= !value[16];
					if (!value[16]) begin
						slot_tid_q[cur_slot_q] <= value[15:0];
					end
				end
				tft_pkg::REQ_X: slot_x_q[cur_slot_q] <= value[16] ? 16'd0 : value[15:0];
				tft_pkg::REQ_Y: slot_y_q[cur_slot_q] <= value[16] ? 16'd0 : value[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tft_pkg::ST_IDLE && in_valid) begin
			now_q <= now_ms;
		end
		if (state_q == tft_pkg::ST_T_EVAL) begin
			wk_q <= ev.nxt;
			drop_q <= ev.drop;
			evv_q <= ev.ev_v;
			evk_q <= ev.ev_kind;
			dxsq_s1 <= ev.dx * ev.dx;
			dysq_s1 <= ev.dy * ev.dy;
		end
		if (state_q == tft_pkg::ST_T_MOVE && in_win) begin
			evv_q <= 1'b1;
			evk_q <= tft_pkg::EV_MOVE;
			wk_q.lx <= wk_q.x;
			wk_q.ly <= wk_q.y;
		end
		if (state_q == tft_pkg::ST_T_WB && !wb_block && ev_pass) begin
			pend_q <= '{id: wk_q.lid, kind: evk_q, x: wk_q.x, y: wk_q.y};
		end
		if ((state_q == tft_pkg::ST_T_WB && !wb_block && ev_pass && pend_v_q) ||
		    (state_q == tft_pkg::ST_FIN && pend_v_q && ofree)) begin
			out_q <= pend_q;
			out_last_q <= state_q == tft_pkg::ST_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
			f_q <= '0;
			k_q <= '0;
			s_q <= '0;
			n_q <= '0;
			phase_q <= 1'b0;
			nid_q <= 16'd0;
			pend_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tft_pkg::ST_IDLE: begin
					f_q <= '0;
					s_q <= '0;
				end
				tft_pkg::ST_CLR_WR: begin
					f_q <= f_last ? '0 : CW'(f_q + 1'b1);
				end
				tft_pkg::ST_SLOT: begin
					if (!s_done) begin
						f_q <= '0;
						phase_q <= 1'b0;
						if (!slot_act_q[sidx]) begin
							s_q <= SCW'(s_q + 1'b1);
						end
					end
				end
				tft_pkg::ST_M_CHK: begin
					if (hit) begin
						s_q <= SCW'(s_q + 1'b1);
					end else if (f_last) begin
						f_q <= '0;
						phase_q <= 1'b1;
					end else begin
						f_q <= CW'(f_q + 1'b1);
					end
				end
				tft_pkg::ST_M_NEW: begin
					s_q <= SCW'(s_q + 1'b1);
					if (!full) begin
						fcount_q <= CW'(fcount_q + 1'b1);
						nid_q <= nid_q + 16'd1;
					end
				end
				tft_pkg::ST_T_START: begin
					f_q <= '0;
					k_q <= '0;
					n_q <= '0;
				end
				tft_pkg::ST_T_WB: begin
					if (!wb_block) begin
						if (ev_pass) begin
							pend_v_q <= 1'b1;
							n_q <= NW'(n_q + 1'b1);
							if (pend_v_q) begin
								out_valid_q <= 1'b1;
							end
						end
						if (!drop_q) begin
							k_q <= CW'(k_q + 1'b1);
						end
						if (f_last) begin
							fcount_q <= CW'(k_q + {{(CW-1){1'b0}}, !drop_q});
						end else begin
							f_q <= CW'(f_q + 1'b1);
						end
					end
				end
				tft_pkg::ST_FIN: begin
					if (pend_v_q && ofree) begin
						pend_v_q <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign finger_id  = out_q.id;
	assign event_kind = out_q.kind;
	assign pos_x      = out_q.x;
	assign pos_y      = out_q.y;
	assign last_event = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= CW'(MAX_TRACKED))
		else $error("finger count beyond table depth");

	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tft_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("pending event left behind at idle");

	a_wb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tft_pkg::ST_T_WB && wb_block) |=>
		(state_q == tft_pkg::ST_T_WB && $stable(k_q)))
		else $error("writeback moved on while output was blocked");

endmodule
